// ===== rtl/gdn_pkg.sv =====
// Package for the Gregorian day number converter: payload and control types,
// field widths, the year-peel step table and calendar helpers.
// No dependencies; every other file of the block but gdn_stream_if imports it.
package gdn_pkg;

  // Default for the top-level year limit
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int COUNT_W = 22;
  localparam int SOD_W   = 17;

  // Working widths: remainder and day accumulator hold 146097 * 32
  localparam int REM_W   = 23;
  localparam int ACC_W   = 23;
  localparam int MREM_W  = 12;   // seconds within an hour

  // Year peel: 6 x 400-year, 2 x 100-year, 5 x 4-year, 2 x 1-year steps
  localparam int NUM_STEPS = 15;
  localparam int STEP_W    = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  // Time of day constants; reciprocals are exact over the legal ranges
  localparam logic [SOD_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [MREM_W-1:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [MREM_W-1:0] SECS_PER_MIN  = 12'd60;
  localparam logic [15:0]       HOUR_RECIP    = 16'd37283;  // 2^27 / 3600, rounded up
  localparam int                HOUR_SHIFT    = 27;
  localparam logic [12:0]       MIN_RECIP     = 13'd4370;   // 2^18 / 60, rounded up
  localparam int                MIN_SHIFT     = 18;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Days before the first of each month in a common year
  localparam logic [8:0] CUM_DAYS [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } gdn_state_t;

  // Which digit of the year offset a peel step belongs to
  typedef enum logic [1:0] {
    GRP_400,
    GRP_100,
    GRP_4,
    GRP_1
  } gdn_grp_t;

  typedef struct packed {
    logic [YEAR_W-1:0] yrs;
    logic [ACC_W-1:0]  days;
    gdn_grp_t          grp;
    logic [2:0]        pos;
  } gdn_step_t;

  typedef struct packed {
    logic                 action;
    logic [YEAR_W-1:0]    in_year;
    logic [MONTH_W-1:0]   in_month;
    logic [DAY_W-1:0]     in_day;
    logic [HOUR_W-1:0]    in_hour;
    logic [MIN_W-1:0]     in_minute;
    logic [SEC_W-1:0]     in_second;
    logic [COUNT_W-1:0]   in_day_count;
    logic [SOD_W-1:0]     in_second_of_day;
  } gdn_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   out_day_count;
    logic [SOD_W-1:0]     out_second_of_day;
    logic [YEAR_W-1:0]    out_year;
    logic [MONTH_W-1:0]   out_month;
    logic [DAY_W-1:0]     out_day;
    logic [HOUR_W-1:0]    out_hour;
    logic [MIN_W-1:0]     out_minute;
    logic [SEC_W-1:0]     out_second;
    logic                 valid_res;
  } gdn_out_t;

  // Sequencer to datapath
  typedef struct packed {
    logic              start;
    logic              year_step;
    logic              month_step;
    logic              finish;
    logic [STEP_W-1:0] step;
  } gdn_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic month_more;
  } gdn_stat_t;

  // Time split and join results
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SOD_W-1:0]  sod_join;
  } gdn_time_t;

  // Year-peel weights, largest first: years and the days they span
  function automatic gdn_step_t step_entry(input logic [STEP_W-1:0] idx);
    gdn_step_t e;
    case (idx)
      4'd0:    e = '{yrs: 14'd12800, days: 23'd4675104, grp: GRP_400, pos: 3'd5};
      4'd1:    e = '{yrs: 14'd6400,  days: 23'd2337552, grp: GRP_400, pos: 3'd4};
      4'd2:    e = '{yrs: 14'd3200,  days: 23'd1168776, grp: GRP_400, pos: 3'd3};
      4'd3:    e = '{yrs: 14'd1600,  days: 23'd584388,  grp: GRP_400, pos: 3'd2};
      4'd4:    e = '{yrs: 14'd800,   days: 23'd292194,  grp: GRP_400, pos: 3'd1};
      4'd5:    e = '{yrs: 14'd400,   days: 23'd146097,  grp: GRP_400, pos: 3'd0};
      4'd6:    e = '{yrs: 14'd200,   days: 23'd73048,   grp: GRP_100, pos: 3'd1};
      4'd7:    e = '{yrs: 14'd100,   days: 23'd36524,   grp: GRP_100, pos: 3'd0};
      4'd8:    e = '{yrs: 14'd64,    days: 23'd23376,   grp: GRP_4,   pos: 3'd4};
      4'd9:    e = '{yrs: 14'd32,    days: 23'd11688,   grp: GRP_4,   pos: 3'd3};
      4'd10:   e = '{yrs: 14'd16,    days: 23'd5844,    grp: GRP_4,   pos: 3'd2};
      4'd11:   e = '{yrs: 14'd8,     days: 23'd2922,    grp: GRP_4,   pos: 3'd1};
      4'd12:   e = '{yrs: 14'd4,     days: 23'd1461,    grp: GRP_4,   pos: 3'd0};
      4'd13:   e = '{yrs: 14'd2,     days: 23'd730,     grp: GRP_1,   pos: 3'd1};
      4'd14:   e = '{yrs: 14'd1,     days: 23'd365,     grp: GRP_1,   pos: 3'd0};
      default: e = '{yrs: '0,        days: '0,          grp: GRP_400, pos: '0};
    endcase
    return e;
  endfunction

  // Leap test from the digits of the year offset (year - 1):
  // last year of a 4-year group, unless it closes a century other than the 4th
  function automatic logic leap_of(input logic [1:0] b, input logic [4:0] c,
                                   input logic [1:0] d);
    return (d == 2'd3) && ((c != 5'd24) || (b == 2'd3));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_FEB:                  len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/gdn_stream_if.sv =====
// Valid/ready stream channel used for the converter's input and result beats.
// The payload type is set per instance; no package dependency.
interface gdn_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gdn_time.sv =====
// Time-of-day unit: splits seconds of day into h/m/s by reciprocal multiply,
// and joins h/m/s into seconds of day. Depends on gdn_pkg.
module gdn_time (
  input  logic             clk,
  input  gdn_pkg::gdn_in_t item,
  output gdn_pkg::gdn_time_t tout
);
  import gdn_pkg::*;

  logic [HOUR_W-1:0] hour_r;
  logic [MREM_W-1:0] min_rem_r;
  logic [MIN_W-1:0]  min_r;
  logic [SEC_W-1:0]  sec_r;
  logic [SOD_W-1:0]  join_r;

  logic [32:0]       hour_prod;
  logic [SOD_W-1:0]  min_base;
  logic [24:0]       min_prod;
  logic [MREM_W-1:0] sec_base;

  // hour = sod / 3600, then remainder, then minute = rem / 60, then second
  assign hour_prod = 33'(item.in_second_of_day) * 33'(HOUR_RECIP);
  assign min_base  = item.in_second_of_day - 17'(hour_r) * 17'(SECS_PER_HOUR);
  assign min_prod  = 25'(min_rem_r) * 25'(MIN_RECIP);
  assign sec_base  = min_rem_r - 12'(min_r) * SECS_PER_MIN;

  // The split settles through hour_r, min_rem_r, min_r and sec_r in that order; the join is registered directly
  always_ff @(posedge clk) begin
    hour_r    <= hour_prod[HOUR_SHIFT +: HOUR_W];
    min_rem_r <= min_base[MREM_W-1:0];
    min_r     <= min_prod[MIN_SHIFT +: MIN_W];
    sec_r     <= sec_base[SEC_W-1:0];
    join_r    <= 17'(item.in_hour) * 17'(SECS_PER_HOUR)
               + 17'(item.in_minute) * 17'(SECS_PER_MIN)
               + 17'(item.in_second);
  end

  assign tout = '{hour: hour_r, minute: min_r, second: sec_r, sod_join: join_r};

endmodule

// ===== rtl/gdn_seq.sv =====
// Sequencer for the converter: steps the shared subtractor through the
// year peel, the month peel (count to date only) and the result load. Depends on gdn_pkg.
module gdn_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                action,
  input  logic                out_free,
  input  gdn_pkg::gdn_stat_t  stat,
  output gdn_pkg::gdn_ctrl_t  ctrl,
  output logic                in_ready
);
  import gdn_pkg::*;

  gdn_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_YEAR;
          step_nxt  = '0;
        end
      end
      ST_YEAR: begin
        step_nxt = step_r + 4'd1;
        if (step_r == LAST_STEP) state_nxt = action ? ST_MONTH : ST_FINISH;
      end
      ST_MONTH: begin
        if (!stat.month_more) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl      = '0;
    ctrl.step = step_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctrl.start = start;
      end
      ST_YEAR:   ctrl.year_step  = 1'b1;
      ST_MONTH:  ctrl.month_step = 1'b1;
      ST_FINISH: ctrl.finish     = out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/gdn_datapath.sv =====
// Converter datapath: one shared compare-and-subtract unit peels years and
// months, plus accumulators, year-offset digits and result assembly.
// Depends on gdn_pkg.
module gdn_datapath #(
  parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
  input  logic                clk,
  input  gdn_pkg::gdn_ctrl_t  ctrl,
  input  gdn_pkg::gdn_in_t    in_item,
  input  gdn_pkg::gdn_in_t    item,
  input  gdn_pkg::gdn_time_t  tsplit,
  output gdn_pkg::gdn_stat_t  stat,
  output gdn_pkg::gdn_out_t   result
);
  import gdn_pkg::*;

  // Last day of year MAX_YEAR, counted from 0001-01-01
  localparam int unsigned LAST_DAY =
    365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400 - 1;

  logic [REM_W-1:0]   rem_r;
  logic [YEAR_W-1:0]  acc_yr_r;
  logic [ACC_W-1:0]   acc_day_r;
  logic [1:0]         dig_b_r;
  logic [4:0]         dig_c_r;
  logic [1:0]         dig_d_r;
  logic [MONTH_W-1:0] mon_r;

  gdn_step_t          st;
  logic               leap;
  logic [DAY_W-1:0]   mlen_run;
  logic [REM_W-1:0]   operand;
  logic [REM_W:0]     diff;
  logic               fits;
  logic [YEAR_W-1:0]  year_m1;

  assign st       = step_entry(ctrl.step);
  assign leap     = leap_of(dig_b_r, dig_c_r, dig_d_r);
  assign mlen_run = month_len(mon_r, leap);
  assign year_m1  = in_item.in_year - 14'd1;

  // Shared unit operand: month length, day weight or year weight
  always_comb begin
    priority if (ctrl.month_step) operand = {18'd0, mlen_run};
    else if (item.action)         operand = st.days;
    else                          operand = {9'd0, st.yrs};
  end

  assign diff = {1'b0, rem_r} - {1'b0, operand};
  assign fits = !diff[REM_W];
  assign stat.month_more = (mon_r != MONTH_DEC) && fits;

  // Peel registers: date to count peels years off (year - 1),
  // count to date peels days off the count
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r     <= in_item.action ? {1'b0, in_item.in_day_count} : {9'd0, year_m1};
      acc_yr_r  <= '0;
      acc_day_r <= '0;
      dig_b_r   <= '0;
      dig_c_r   <= '0;
      dig_d_r   <= '0;
      mon_r     <= MONTH_JAN;
    end else if (ctrl.year_step && fits) begin
      rem_r     <= diff[REM_W-1:0];
      acc_yr_r  <= acc_yr_r + st.yrs;
      acc_day_r <= acc_day_r + st.days;
      unique case (st.grp)
        GRP_400: ;
        GRP_100: dig_b_r[st.pos[0]] <= 1'b1;
        GRP_4:   dig_c_r[st.pos]    <= 1'b1;
        GRP_1:   dig_d_r[st.pos[0]] <= 1'b1;
      endcase
    end else if (ctrl.month_step && stat.month_more) begin
      rem_r <= diff[REM_W-1:0];
      mon_r <= mon_r + 4'd1;
    end
  end

  // Date to count checks and sum
  logic               month_ok, year_ok, date_ok, time_ok, feb_adj, in_ok;
  logic [MONTH_W-1:0] m_idx;
  logic [DAY_W-1:0]   mlen_in, d_m1;
  logic [ACC_W-1:0]   count_full;

  assign month_ok = (item.in_month >= MONTH_JAN) && (item.in_month <= MONTH_DEC);
  assign m_idx    = month_ok ? item.in_month - 4'd1 : '0;
  assign mlen_in  = month_len(month_ok ? item.in_month : MONTH_JAN, leap);
  assign year_ok  = (item.in_year != '0) && ({18'd0, item.in_year} <= MAX_YEAR);
  assign date_ok  = year_ok && month_ok && (item.in_day != '0) && (item.in_day <= mlen_in);
  assign time_ok  = (item.in_hour < 5'd24) && (item.in_minute < 6'd60)
                 && (item.in_second < 6'd60);
  assign feb_adj  = leap && (item.in_month > MONTH_FEB);
  assign d_m1     = item.in_day - 5'd1;
  assign count_full = acc_day_r + {14'd0, CUM_DAYS[m_idx]} + {22'd0, feb_adj}
                    + {18'd0, d_m1};

  // Count to date range check
  assign in_ok = ({10'd0, item.in_day_count} <= LAST_DAY)
              && (item.in_second_of_day < SECS_PER_DAY);

  // Result assembly; fields of the other direction stay zero
  always_comb begin
    result = '0;
    if (!item.action) begin
      result.out_day_count     = date_ok ? count_full[COUNT_W-1:0] : '0;
      result.out_second_of_day = time_ok ? tsplit.sod_join : '0;
      result.valid_res         = date_ok && time_ok;
    end else if (in_ok) begin
      result.out_year   = acc_yr_r + 14'd1;
      result.out_month  = mon_r;
      result.out_day    = rem_r[DAY_W-1:0] + 5'd1;
      result.out_hour   = tsplit.hour;
      result.out_minute = tsplit.minute;
      result.out_second = tsplit.second;
      result.valid_res  = 1'b1;
    end
  end

endmodule

// ===== rtl/gregorian_day_number_converter_top.sv =====
// Gregorian day number converter, top level. Uses gdn_pkg, gdn_stream_if,
// gdn_seq, gdn_datapath and gdn_time.
// Flow: the input beat starts the sequencer, which steps the shared subtractor
// through the 15 year-peel steps, then, for count to date, one step per month
// peeled, then loads the result once the output is free. One item in flight;
// the next input beat can be taken in the cycle after the result is loaded.
// Reset (synchronous, active low) idles the sequencer and empties the output.
module gregorian_day_number_converter_top #(
  parameter int unsigned MAX_YEAR = gdn_pkg::MAX_YEAR_DEF
) (
  input logic          clk,
  input logic          rst_n,
  gdn_stream_if.sink   in_ch,
  gdn_stream_if.source out_ch
);
  import gdn_pkg::*;

  gdn_in_t    in_item;
  gdn_in_t    item_r;
  gdn_out_t   out_r;
  gdn_out_t   result;
  logic       out_valid_r;
  logic       in_ready;
  logic       accept;
  logic       out_free;
  gdn_ctrl_t  ctrl;
  gdn_stat_t  stat;
  gdn_time_t  tsplit;

  assign in_item     = in_ch.data;
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Capture the input beat for the length of the item
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
  end

  gdn_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .action   (item_r.action),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  gdn_time u_time (
    .clk  (clk),
    .item (item_r),
    .tout (tsplit)
  );

  gdn_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk     (clk),
    .ctrl    (ctrl),
    .in_item (in_item),
    .item    (item_r),
    .tsplit  (tsplit),
    .stat    (stat),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) out_r <= result;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.data.out_year != '0)) |->
      ((out_ch.data.out_day_count == '0) && (out_ch.data.out_second_of_day == '0)))
    else $error("result carries fields of both directions");

  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.valid_res && (out_ch.data.out_year != '0)) |->
      ((out_ch.data.out_month >= 4'd1) && (out_ch.data.out_month <= 4'd12) &&
       (out_ch.data.out_day >= 5'd1) && (out_ch.data.out_day <= 5'd31) &&
       (out_ch.data.out_hour < 5'd24)))
    else $error("peeled date or time out of range");

  a_sod_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.out_second_of_day < SECS_PER_DAY))
    else $error("seconds of day out of range");

endmodule
